// ===== hdl/pgc_pkg.sv =====
package pgc_pkg;

    localparam int MAX_ANGLES = 16;
    localparam int MAX_RADII  = 1024;
    localparam int MAX_IMAGE  = 2048;

    localparam int AW      = $clog2(MAX_ANGLES);
    localparam int RW      = $clog2(MAX_RADII);
    localparam int BANK_AW = AW + RW - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam int VAL_W    = 16;
    localparam int SUM_W    = 25;
    localparam int SQRT_PAD = 14;
    localparam int ROOT_W   = 20;
    localparam int REM_W    = 22;
    localparam int STEP_W   = 7;
    localparam int CW       = 24;
    localparam int ZW       = 18;
    localparam int THETA_W  = 17;
    localparam int APOS_W   = 12;

    localparam int SQRT_CELLS   = ROOT_W;
    localparam int DIV_CELLS    = ROOT_W;
    localparam int CORDIC_CELLS = 16;

    localparam int ST_APOS = CORDIC_CELLS + 2;
    localparam int ST_RQ   = 2 + SQRT_CELLS + DIV_CELLS;

    localparam logic [1:0] CFG_IMAGE_SIZE   = 2'd0;
    localparam logic [1:0] CFG_RADIUS_STEP  = 2'd1;
    localparam logic [1:0] CFG_ANGLE_COUNT  = 2'd2;
    localparam logic [1:0] CFG_RADIUS_COUNT = 2'd3;

    localparam logic [11:0] RST_IMAGE_SIZE   = 12'd512;
    localparam logic [6:0]  RST_RADIUS_STEP  = 7'd2;
    localparam logic [4:0]  RST_ANGLE_COUNT  = 5'd5;
    localparam logic [10:0] RST_RADIUS_COUNT = 11'd128;

    typedef struct packed {
        logic              vld;
        logic              pix;
        logic              zero;
        logic [AW-1:0]     row;
        logic [RW-1:0]     col;
        logic [VAL_W-1:0]  val;
        logic [APOS_W-1:0] apos;
    } t_side;

    typedef struct packed {
        logic       vld;
        logic       pix;
        logic       inr;
        logic       pa;
        logic       pr;
        logic [7:0] fr;
        logic [8:0] fa;
    } t_tail;

    // Arctangent of 2^-i in units where pi is 65536.
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 18'sd16384;
            1:       v = 18'sd9672;
            2:       v = 18'sd5110;
            3:       v = 18'sd2594;
            4:       v = 18'sd1302;
            5:       v = 18'sd652;
            6:       v = 18'sd326;
            7:       v = 18'sd163;
            8:       v = 18'sd81;
            9:       v = 18'sd41;
            10:      v = 18'sd20;
            11:      v = 18'sd10;
            12:      v = 18'sd5;
            13:      v = 18'sd3;
            14:      v = 18'sd1;
            15:      v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/pgc_sqrt_cell.sv =====
module pgc_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [pgc_pkg::SUM_W-1:0]    i_sum,
    input  logic [pgc_pkg::REM_W-1:0]    i_rem,
    input  logic [pgc_pkg::ROOT_W-1:0]   i_root,
    output logic [pgc_pkg::SUM_W-1:0]    o_sum,
    output logic [pgc_pkg::REM_W-1:0]    o_rem,
    output logic [pgc_pkg::ROOT_W-1:0]   o_root
);
    import pgc_pkg::*;

    localparam int RAD_W = 2 * ROOT_W;

    logic [RAD_W-1:0]   w_rad;
    logic [1:0]         w_pair;
    logic [REM_W+1:0]   w_t;
    logic [REM_W+1:0]   w_trial;
    logic [REM_W+1:0]   w_diff;
    logic               w_ge;
    logic [SUM_W-1:0]   r_sum;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;

    // The radicand is the squared distance scaled by 2^14; each cell takes two bits of it.
    assign w_rad   = {{(RAD_W-SUM_W-SQRT_PAD){1'b0}}, i_sum, {SQRT_PAD{1'b0}}};
    assign w_pair  = w_rad[RAD_W-1-2*K -: 2];
    assign w_t     = {i_rem, w_pair};
    assign w_trial = {{(REM_W-ROOT_W){1'b0}}, i_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);
    assign w_diff  = w_t - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= i_sum;
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_t[REM_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_sum  = r_sum;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// ===== hdl/pgc_div_cell.sv =====
module pgc_div_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [pgc_pkg::STEP_W-1:0]   i_den,
    input  logic [pgc_pkg::STEP_W-1:0]   i_rem,
    input  logic [pgc_pkg::ROOT_W-1:0]   i_nq,
    output logic [pgc_pkg::STEP_W-1:0]   o_rem,
    output logic [pgc_pkg::ROOT_W-1:0]   o_nq
);
    import pgc_pkg::*;

    logic [STEP_W:0]    w_t;
    logic [STEP_W:0]    w_diff;
    logic               w_ge;
    logic [STEP_W-1:0]  r_rem;
    logic [ROOT_W-1:0]  r_nq;

    // Numerator bits leave at the top while quotient bits enter at the bottom.
    assign w_t    = {i_rem, i_nq[ROOT_W-1]};
    assign w_ge   = (w_t >= {1'b0, i_den});
    assign w_diff = w_t - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[STEP_W-1:0] : w_t[STEP_W-1:0];
            r_nq  <= {i_nq[ROOT_W-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_nq  = r_nq;

endmodule

// ===== hdl/pgc_cordic_cell.sv =====
module pgc_cordic_cell #(
    parameter int I = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [pgc_pkg::CW-1:0]    i_x,
    input  logic signed [pgc_pkg::CW-1:0]    i_y,
    input  logic signed [pgc_pkg::ZW-1:0]    i_z,
    output logic signed [pgc_pkg::CW-1:0]    o_x,
    output logic signed [pgc_pkg::CW-1:0]    o_y,
    output logic signed [pgc_pkg::ZW-1:0]    o_z
);
    import pgc_pkg::*;

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [ZW-1:0] w_a;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    assign w_xs = i_x >>> I;
    assign w_ys = i_y >>> I;
    assign w_a  = atan_step(I);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[CW-1]) begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + w_a;
            end else begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - w_a;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ===== hdl/polar_grid_to_cartesian_resample_core.sv =====
// A pixel item passes the input, square, distance, square-root, divider, table read,
// interpolation and output registers. Throughput: one item per cycle unless the pipeline
// halts, as set by the square-root, divider and CORDIC cells, each retiring one step per cycle.
// Table writes travel the same pipeline and land in the table in item order.
// Reset (synchronous, active low) empties the pipeline and restores the
// configuration registers; table contents are not cleared.
module polar_grid_to_cartesian_resample_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [3:0]  i_angle_index,
    input  logic [9:0]  i_radius_index,
    input  logic [15:0] i_table_value,
    input  logic [10:0] i_pixel_x,
    input  logic [10:0] i_pixel_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pixel_value,
    output logic        o_in_range
);
    import pgc_pkg::*;

    // configuration
    logic [11:0] r_image_size;
    logic [6:0]  r_radius_step;
    logic [4:0]  r_angle_count;
    logic [10:0] r_radius_count;
    logic [11:0] w_n;
    logic [6:0]  w_step;
    logic [4:0]  w_acnt;
    logic [4:0]  w_acm1_full;
    logic [3:0]  w_acm1;
    logic [10:0] w_rcnt;

    logic w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size   <= RST_IMAGE_SIZE;
            r_radius_step  <= RST_RADIUS_STEP;
            r_angle_count  <= RST_ANGLE_COUNT;
            r_radius_count <= RST_RADIUS_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_SIZE:   r_image_size   <= i_cfg_data;
                CFG_RADIUS_STEP:  r_radius_step  <= i_cfg_data[6:0];
                CFG_ANGLE_COUNT:  r_angle_count  <= i_cfg_data[4:0];
                CFG_RADIUS_COUNT: r_radius_count <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign w_n    = (r_image_size > 12'(MAX_IMAGE)) ? 12'(MAX_IMAGE) : r_image_size;
    assign w_step = (r_radius_step == 7'd0) ? 7'd1 : r_radius_step;
    assign w_acnt = (r_angle_count < 5'd2) ? 5'd2 :
                    (r_angle_count > 5'(MAX_ANGLES)) ? 5'(MAX_ANGLES) : r_angle_count;
    assign w_acm1_full = w_acnt - 5'd1;
    assign w_acm1      = w_acm1_full[3:0];
    assign w_rcnt = (r_radius_count > 11'(MAX_RADII)) ? 11'(MAX_RADII) : r_radius_count;

    // stage 0: input register
    logic signed [14:0] w_dx_full;
    logic signed [14:0] w_dy_full;
    logic signed [14:0] w_dy_abs;
    logic signed [12:0] r_dx;
    logic [11:0]        r_dy;
    t_side              w_sd_in;
    t_side              r_sd [0:ST_RQ];

    assign o_in_ready = w_en && i_rst_n;

    assign w_dx_full = $signed({3'b0, i_pixel_x, 1'b0}) - $signed({3'b0, w_n});
    assign w_dy_full = $signed({3'b0, i_pixel_y, 1'b0}) - $signed({3'b0, w_n});
    assign w_dy_abs  = w_dy_full[14] ? -w_dy_full : w_dy_full;

    always_comb begin
        w_sd_in      = '0;
        w_sd_in.vld  = i_in_valid;
        w_sd_in.pix  = i_operation;
        w_sd_in.zero = (w_dx_full == 15'sd0) && (w_dy_full == 15'sd0);
        w_sd_in.row  = i_angle_index;
        w_sd_in.col  = i_radius_index;
        w_sd_in.val  = i_table_value;
    end

    logic [THETA_W-1:0]  w_theta;
    logic [20:0]         w_apos_prod;
    t_side               w_sd_apos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= ST_RQ; j++) begin
                r_sd[j].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_sd[0] <= w_sd_in;
            for (int j = 1; j <= ST_RQ; j++) begin
                r_sd[j] <= (j == ST_APOS) ? w_sd_apos : r_sd[j-1];
            end
        end
    end

    // stage 1: squares and CORDIC pre-rotation; stage 2: squared distance
    logic signed [25:0]   w_dx2f;
    logic [23:0]          w_dy2f;
    logic [23:0]          r_dx2;
    logic [23:0]          r_dy2;
    logic [SUM_W-1:0]     r_sum;
    logic signed [CW-1:0] w_x0;
    logic signed [CW-1:0] w_y0;
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [ZW-1:0] r_cz;

    assign w_dx2f = $signed({{13{r_dx[12]}}, r_dx}) * $signed({{13{r_dx[12]}}, r_dx});
    assign w_dy2f = {12'b0, r_dy} * {12'b0, r_dy};
    assign w_x0   = {{3{r_dx[12]}}, r_dx, 8'b0};
    assign w_y0   = {4'b0, r_dy, 8'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx  <= w_dx_full[12:0];
            r_dy  <= w_dy_abs[11:0];
            r_dx2 <= w_dx2f[23:0];
            r_dy2 <= w_dy2f;
            r_sum <= {1'b0, r_dx2} + {1'b0, r_dy2};
            // Left half plane: rotate by a quarter turn first.
            if (r_dx[12]) begin
                r_cx <= w_y0;
                r_cy <= -w_x0;
                r_cz <= 18'sd32768;
            end else begin
                r_cx <= w_x0;
                r_cy <= w_y0;
                r_cz <= 18'sd0;
            end
        end
    end

    // square-root cells
    logic [SUM_W-1:0]  w_sq_sum  [0:SQRT_CELLS];
    logic [REM_W-1:0]  w_sq_rem  [0:SQRT_CELLS];
    logic [ROOT_W-1:0] w_sq_root [0:SQRT_CELLS];

    assign w_sq_sum[0]  = r_sum;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        pgc_sqrt_cell #(.K(k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sum  (w_sq_sum[k]),
            .i_rem  (w_sq_rem[k]),
            .i_root (w_sq_root[k]),
            .o_sum  (w_sq_sum[k+1]),
            .o_rem  (w_sq_rem[k+1]),
            .o_root (w_sq_root[k+1])
        );
    end

    // divider cells: radius index in Q8 is the root divided by the step
    logic [STEP_W-1:0] w_dv_rem [0:DIV_CELLS];
    logic [ROOT_W-1:0] w_dv_nq  [0:DIV_CELLS];

    assign w_dv_rem[0] = '0;
    assign w_dv_nq[0]  = w_sq_root[SQRT_CELLS];

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        pgc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (w_step),
            .i_rem (w_dv_rem[k]),
            .i_nq  (w_dv_nq[k]),
            .o_rem (w_dv_rem[k+1]),
            .o_nq  (w_dv_nq[k+1])
        );
    end

    // CORDIC cells
    logic signed [CW-1:0] w_cx [0:CORDIC_CELLS];
    logic signed [CW-1:0] w_cy [0:CORDIC_CELLS];
    logic signed [ZW-1:0] w_cz [0:CORDIC_CELLS];

    assign w_cx[0] = r_cx;
    assign w_cy[0] = r_cy;
    assign w_cz[0] = r_cz;

    for (genvar k = 0; k < CORDIC_CELLS; k++) begin : g_cordic
        pgc_cordic_cell #(.I(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_cx[k]),
            .i_y   (w_cy[k]),
            .i_z   (w_cz[k]),
            .o_x   (w_cx[k+1]),
            .o_y   (w_cy[k+1]),
            .o_z   (w_cz[k+1])
        );
    end

    // Angle clamp and scaling to angle rows, in Q8.
    always_comb begin
        if (r_sd[ST_APOS-1].zero || w_cz[CORDIC_CELLS][ZW-1]) begin
            w_theta = '0;
        end else if (w_cz[CORDIC_CELLS] > 18'sd65536) begin
            w_theta = 17'd65536;
        end else begin
            w_theta = w_cz[CORDIC_CELLS][THETA_W-1:0];
        end
    end

    assign w_apos_prod = {4'b0, w_theta} * {17'b0, w_acm1};

    always_comb begin
        w_sd_apos      = r_sd[ST_APOS-1];
        w_sd_apos.apos = w_apos_prod[APOS_W+7:8];
    end

    // Neighbor selection and table access.
    t_side       w_sq;
    logic [ROOT_W-1:0] w_rq8;
    logic [11:0] w_r1;
    logic [7:0]  w_fr;
    logic        w_out;
    logic [3:0]  w_a1raw;
    logic [3:0]  w_a1;
    logic [12:0] w_fa_full;
    logic [AW-1:0] w_row0;
    logic [AW-1:0] w_row1;
    logic [RW-1:0] w_col0;
    logic [RW-1:0] w_col1;
    logic [BANK_AW-1:0] w_raddr [0:3];
    logic [BANK_AW-1:0] w_waddr;
    logic [1:0]  w_wbank;
    logic        w_we;
    logic [VAL_W-1:0] r_rd [0:3];

    assign w_sq    = r_sd[ST_RQ];
    assign w_rq8   = w_dv_nq[DIV_CELLS];
    assign w_r1    = w_rq8[ROOT_W-1:8];
    assign w_fr    = w_rq8[7:0];
    assign w_out   = (({1'b0, w_r1} + 13'd1) >= {2'b0, w_rcnt});
    assign w_a1raw = w_sq.apos[APOS_W-1:8];
    // On the last angle row, blend fully toward the upper row instead.
    assign w_a1    = (w_a1raw >= w_acm1) ? (w_acm1 - 4'd1) : w_a1raw;
    assign w_fa_full = {1'b0, w_sq.apos} - {1'b0, w_a1, 8'b0};
    assign w_row0  = w_a1;
    assign w_row1  = w_a1 + 4'd1;
    assign w_col0  = w_r1[RW-1:0];
    assign w_col1  = w_r1[RW-1:0] + 10'd1;

    // Four banks split by row and column parity, so the four neighbors are read at once.
    for (genvar b = 0; b < 4; b++) begin : g_addr
        localparam logic [1:0] BANK = 2'(b);
        logic [AW-1:0] w_row;
        logic [RW-1:0] w_col;
        assign w_row = (w_a1[0] == BANK[1]) ? w_row0 : w_row1;
        assign w_col = (w_r1[0] == BANK[0]) ? w_col0 : w_col1;
        assign w_raddr[b] = {w_row[AW-1:1], w_col[RW-1:1]};
    end

    assign w_wbank = {w_sq.row[0], w_sq.col[0]};
    assign w_waddr = {w_sq.row[AW-1:1], w_sq.col[RW-1:1]};
    assign w_we    = w_sq.vld && !w_sq.pix;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [VAL_W-1:0] r_mem [0:BANK_DEPTH-1];
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_we && (w_wbank == 2'(b))) begin
                    r_mem[w_waddr] <= w_sq.val;
                end
                r_rd[b] <= r_mem[w_raddr[b]];
            end
        end
    end

    // Interpolation stages.
    t_tail w_tl_in;
    t_tail r_tl [43:46];
    logic [VAL_W-1:0] w_v00;
    logic [VAL_W-1:0] w_v01;
    logic [VAL_W-1:0] w_v10;
    logic [VAL_W-1:0] w_v11;
    logic [8:0]  w_wr0;
    logic [24:0] w_p00;
    logic [24:0] w_p01;
    logic [24:0] w_p10;
    logic [24:0] w_p11;
    logic [23:0] r_p00;
    logic [23:0] r_p01;
    logic [23:0] r_p10;
    logic [23:0] r_p11;
    logic [23:0] r_g1;
    logic [23:0] r_g2;
    logic [8:0]  w_wa0;
    logic [32:0] w_m1;
    logic [32:0] w_m2;
    logic [32:0] r_m1;
    logic [32:0] r_m2;
    logic [32:0] w_acc;

    always_comb begin
        w_tl_in     = '0;
        w_tl_in.vld = w_sq.vld;
        w_tl_in.pix = w_sq.pix;
        w_tl_in.inr = !w_out;
        w_tl_in.pa  = w_a1[0];
        w_tl_in.pr  = w_r1[0];
        w_tl_in.fr  = w_fr;
        w_tl_in.fa  = w_fa_full[8:0];
    end

    assign w_v00 = r_rd[{r_tl[43].pa, r_tl[43].pr}];
    assign w_v01 = r_rd[{r_tl[43].pa, !r_tl[43].pr}];
    assign w_v10 = r_rd[{!r_tl[43].pa, r_tl[43].pr}];
    assign w_v11 = r_rd[{!r_tl[43].pa, !r_tl[43].pr}];
    assign w_wr0 = 9'd256 - {1'b0, r_tl[43].fr};
    assign w_p00 = {16'b0, w_wr0} * {9'b0, w_v00};
    assign w_p01 = {17'b0, r_tl[43].fr} * {9'b0, w_v01};
    assign w_p10 = {16'b0, w_wr0} * {9'b0, w_v10};
    assign w_p11 = {17'b0, r_tl[43].fr} * {9'b0, w_v11};
    assign w_wa0 = 9'd256 - r_tl[45].fa;
    assign w_m1  = {24'b0, w_wa0} * {9'b0, r_g1};
    assign w_m2  = {24'b0, r_tl[45].fa} * {9'b0, r_g2};
    assign w_acc = r_m1 + r_m2 + 33'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 43; j <= 46; j++) begin
                r_tl[j].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_tl[43] <= w_tl_in;
            for (int j = 44; j <= 46; j++) begin
                r_tl[j] <= r_tl[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p00 <= w_p00[23:0];
            r_p01 <= w_p01[23:0];
            r_p10 <= w_p10[23:0];
            r_p11 <= w_p11[23:0];
            r_g1  <= r_p00 + r_p01;
            r_g2  <= r_p10 + r_p11;
            r_m1  <= w_m1;
            r_m2  <= w_m2;
        end
    end

    // Output register; the pipeline only halts when a pixel would overwrite a waiting result.
    logic             w_last_pix;
    logic             r_ovld;
    logic [VAL_W-1:0] r_pixel_value;
    logic             r_in_range;

    assign w_last_pix = r_tl[46].vld && r_tl[46].pix;
    assign w_en       = !(r_ovld && !i_out_ready && w_last_pix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            if (r_ovld && i_out_ready) begin
                r_ovld <= 1'b0;
            end
            if (w_en && w_last_pix) begin
                r_ovld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_last_pix) begin
            r_pixel_value <= r_tl[46].inr ? w_acc[31:16] : '0;
            r_in_range    <= r_tl[46].inr;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_pixel_value = r_pixel_value;
    assign o_in_range    = r_in_range;

endmodule

// ===== tb/polar_grid_to_cartesian_resample_core_tb.sv =====
module polar_grid_to_cartesian_resample_core_tb;
    import pgc_pkg::*;

    localparam int LIMIT_CYCLES = 20000;
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_operation;
    logic [3:0]  i_angle_index;
    logic [9:0]  i_radius_index;
    logic [15:0] i_table_value;
    logic [10:0] i_pixel_x;
    logic [10:0] i_pixel_y;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_pixel_value;
    logic        o_in_range;

    polar_grid_to_cartesian_resample_core DUT (.*);

    typedef struct {
        logic [15:0] value;
        logic        inr;
    } t_pixel;

    class resample_scoreboard;
        logic [15:0] polar_mem [MAX_ANGLES*MAX_RADII];
        bit          written   [MAX_ANGLES*MAX_RADII];
        int unsigned img_size, rad_step, ang_count, rad_count;
        t_pixel      expected_pixels [$];
        int          errors;
        longint      atan_lut [16] = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163,
                                       81, 41, 20, 10, 5, 3, 1, 1};

        function new();
            img_size  = RST_IMAGE_SIZE;
            rad_step  = RST_RADIUS_STEP;
            ang_count = RST_ANGLE_COUNT;
            rad_count = RST_RADIUS_COUNT;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_IMAGE_SIZE:   img_size  = data;
                CFG_RADIUS_STEP:  rad_step  = data[6:0];
                CFG_ANGLE_COUNT:  ang_count = data[4:0];
                CFG_RADIUS_COUNT: rad_count = data[10:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned a);
            longint unsigned root, trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= a) root = trial;
            end
            return root;
        endfunction

        // Folded angle with pi equal to 65536, by shift-and-add rotation.
        function int unsigned polar_angle(int dx, int dy);
            longint x, y, z, xs, ys, t;
            if (dx == 0 && dy == 0) return 0;
            x = longint'(dx) * 256;
            y = longint'(dy) * 256;
            z = 0;
            if (x < 0) begin
                t = x;
                x = y;
                y = -t;
                z = 32768;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys;
                    y -= xs;
                    z += atan_lut[i];
                end else begin
                    x -= ys;
                    y += xs;
                    z -= atan_lut[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 65536) z = 65536;
            return int'(z);
        endfunction

        // Finds the lower neighbour cell and weights; returns 0 when out of range.
        function bit locate(int px, int py, output int a1, output int r1,
                            output int fa, output int fr);
            int unsigned n, stp, ac, rc, theta, apos;
            int dx, dy;
            longint unsigned s, rq8;
            n   = img_size > MAX_IMAGE ? MAX_IMAGE : img_size;
            stp = rad_step == 0 ? 1 : rad_step;
            ac  = ang_count < 2 ? 2 : (ang_count > MAX_ANGLES ? MAX_ANGLES : ang_count);
            rc  = rad_count > MAX_RADII ? MAX_RADII : rad_count;
            dx  = 2 * px - int'(n);
            dy  = 2 * py - int'(n);
            if (dy < 0) dy = -dy;
            s   = longint'(dx) * dx + longint'(dy) * dy;
            rq8 = int_sqrt(s << 14) / stp;
            if ((rq8 >> 8) + 1 >= rc) return 0;
            r1    = int'(rq8 >> 8);
            fr    = int'(rq8 & 255);
            theta = polar_angle(dx, dy);
            apos  = (theta * (ac - 1)) >> 8;
            a1    = apos >> 8;
            if (a1 >= ac - 1) a1 = ac - 2;
            fa    = apos - (a1 << 8);
            return 1;
        endfunction

        function void note_item(bit op, int ai, int ri, int tv, int px, int py);
            int a1, r1, fa, fr;
            longint unsigned g1, g2, acc;
            t_pixel p;
            if (!op) begin
                polar_mem[ai*MAX_RADII + ri] = 16'(tv);
                written[ai*MAX_RADII + ri]   = 1;
                return;
            end
            if (!locate(px, py, a1, r1, fa, fr)) begin
                p.value = 0;
                p.inr   = 0;
            end else begin
                g1 = (256 - fr) * polar_mem[a1*MAX_RADII + r1]
                   + fr * polar_mem[a1*MAX_RADII + r1 + 1];
                g2 = (256 - fr) * polar_mem[(a1+1)*MAX_RADII + r1]
                   + fr * polar_mem[(a1+1)*MAX_RADII + r1 + 1];
                acc = (256 - fa) * g1 + fa * g2 + 32768;
                p.value = acc[31:16];
                p.inr   = 1;
            end
            expected_pixels.push_back(p);
        endfunction

        function void check_pixel(logic [15:0] value, logic inr);
            t_pixel p;
            if (expected_pixels.size() == 0) begin
                $display("%0t unexpected item: expected none, actual value %0d in_range %0d",
                         $time, value, inr);
                errors++;
                return;
            end
            p = expected_pixels.pop_front();
            if (value !== p.value) begin
                $display("%0t pixel_value mismatch: expected %0d actual %0d",
                         $time, p.value, value);
                errors++;
            end
            if (inr !== p.inr) begin
                $display("%0t in_range mismatch: expected %0d actual %0d",
                         $time, p.inr, inr);
                errors++;
            end
        endfunction
    endclass

    resample_scoreboard sb;
    bit hold_req;
    bit send_burst;
    int idle_cycles;
    int sent_items;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Any accepted item on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT_CYCLES) begin
            $display("FAIL polar_grid_to_cartesian_resample_core");
            $finish;
        end
    end

    task automatic send_item(bit op, int ai, int ri, int tv, int px, int py);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1;
        i_operation    <= op;
        i_angle_index  <= 4'(ai);
        i_radius_index <= 10'(ri);
        i_table_value  <= 16'(tv);
        i_pixel_x      <= 11'(px);
        i_pixel_y      <= 11'(py);
        forever begin
            @(negedge i_clk);
            if (o_in_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        sb.note_item(op, ai, ri, tv, px, py);
        sent_items++;
    endtask

    task automatic send_write(int ai, int ri, int tv);
        send_item(0, ai, ri, tv, $urandom_range(0, 2047), $urandom_range(0, 2047));
    endtask

    // Makes sure all four neighbour entries hold data before the pixel is sent.
    task automatic send_pixel(int px, int py);
        int a1, r1, fa, fr;
        if (sb.locate(px, py, a1, r1, fa, fr)) begin
            for (int k = 0; k < 4; k++) begin
                if (!sb.written[(a1 + k/2)*MAX_RADII + r1 + k%2])
                    send_write(a1 + k/2, r1 + k%2, $urandom_range(0, 65535));
            end
        end
        send_item(1, $urandom_range(0, 15), $urandom_range(0, 1023),
                  $urandom_range(0, 65535), px, py);
    endtask

    task automatic write_config(int img, int stp, int ac, int rc);
        int vals [4];
        vals = '{img, stp, ac, rc};
        i_in_valid <= 0;
        while (sb.expected_pixels.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1;
            i_cfg_index <= k[1:0];
            i_cfg_data  <= 12'(vals[k]);
            @(posedge i_clk);
            sb.set_reg(k[1:0], 12'(vals[k]));
        end
        i_cfg_we <= 0;
    endtask

    // Sends items until the given number, neighbour writes included, is reached.
    task automatic random_phase(int count);
        int n, span, start;
        n     = sb.img_size > MAX_IMAGE ? MAX_IMAGE : sb.img_size;
        span  = n > 1 ? n - 1 : 1;
        start = sent_items;
        while (sent_items - start < count) begin
            if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
            if ($urandom_range(0, 3) == 0)
                send_write($urandom_range(0, 15), $urandom_range(0, 1023),
                           $urandom_range(0, 65535));
            else if ($urandom_range(0, 4) == 0)
                send_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
            else
                send_pixel($urandom_range(0, span), $urandom_range(0, span));
        end
    endtask

    initial begin
        i_out_ready <= 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int stall;
            if (hold_req) begin
                i_out_ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_out_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1;
            forever begin
                logic [15:0] value;
                logic        inr;
                @(negedge i_clk);
                value = o_pixel_value;
                inr   = o_in_range;
                if (o_out_valid) begin
                    @(posedge i_clk);
                    sb.check_pixel(value, inr);
                    break;
                end
                @(posedge i_clk);
            end
        end
    end

    initial begin
        sb          = new();
        hold_req    = 0;
        send_burst  = 0;
        idle_cycles = 0;
        sent_items  = 0;
        i_rst_n        <= 0;
        i_cfg_we       <= 0;
        i_cfg_index    <= CFG_IMAGE_SIZE;
        i_cfg_data     <= 0;
        i_in_valid     <= 0;
        i_operation    <= 0;
        i_angle_index  <= 0;
        i_radius_index <= 0;
        i_table_value  <= 0;
        i_pixel_x      <= 0;
        i_pixel_y      <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed items under the reset settings (grid 512, centre 256).
        send_write(15, 1023, 65535);
        send_write(0, 0, 0);
        send_write(15, 0, 16'h5555);
        send_write(0, 1023, 16'hAAAA);
        send_pixel(256, 256);
        send_pixel(257, 256);
        send_pixel(200, 256);
        send_pixel(256, 200);
        send_pixel(256, 312);
        send_pixel(255, 300);
        send_pixel(0, 0);
        send_pixel(2047, 2047);
        send_pixel(383, 256);
        send_pixel(384, 256);
        send_pixel(300, 290);

        // The first phase keeps the sender busy while the receiver holds off.
        send_burst = 1;
        hold_req   = 1;
        random_phase(250);
        send_burst = 0;

        write_config(2048, 1, 16, 1024);
        random_phase(200);
        write_config(2, 64, 2, 1);
        random_phase(80);
        write_config(4095, 0, 0, 2047);
        random_phase(200);
        write_config(300, 127, 31, 50);
        random_phase(150);
        write_config(64, 1, 17, 8);
        random_phase(150);
        write_config(1000, 7, 9, 400);
        random_phase(200);
        write_config(0, 5, 1, 20);
        random_phase(150);
        write_config(100, 3, 3, 1023);
        random_phase(200);

        i_in_valid <= 0;
        while (sb.expected_pixels.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS polar_grid_to_cartesian_resample_core");
        else
            $display("FAIL polar_grid_to_cartesian_resample_core");
        $finish;
    end
endmodule
